### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/qmps_pkg.sv
// ----------------------------------------------------------------------------
// qmps_pkg
// Types, constants and mask functions of the QR mask penalty selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qmps_pkg;

    localparam int NUM_MASKS   = 8;
    localparam int PATTERN_LEN = 11;
    localparam int RUN_W       = 8;
    localparam int RWIN_W      = 11;
    localparam int CWIN_W      = 10;
    localparam int CENT_W      = RUN_W + CWIN_W;
    localparam int MEM_W       = NUM_MASKS * CENT_W;
    localparam int DARK_W      = 15;
    localparam int SCORE_W     = 22;
    localparam int AREA_W      = 15;
    localparam int DIVD_W      = 22;
    localparam int PCT_W       = 13;
    localparam int PROD_W      = 30;
    localparam int DIV_STEPS   = DIVD_W;

    localparam logic [RWIN_W-1:0]  FINDER_A  = 11'h5D0;
    localparam logic [RWIN_W-1:0]  FINDER_B  = 11'h05D;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 22'h3FFFFF;
    localparam logic [RUN_W-1:0]   RUN_MAX   = 8'd255;
    localparam logic [DARK_W-1:0]  DARK_MAX  = 15'h7FFF;
    localparam logic [6:0]         PEN_RUN5  = 7'd3;
    localparam logic [6:0]         PEN_BLOCK = 7'd3;
    localparam logic [6:0]         PEN_FIND  = 7'd40;
    localparam logic [PCT_W-1:0]   PCT_HALF  = 13'd50;
    localparam logic [16:0]        RECIP5    = 17'd52429;  // 2^18 / 5, rounded up
    localparam logic [6:0]         PCT_SCALE = 7'd100;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_EMIT_MOD,
        S_FIN_AREA,
        S_FIN_INIT,
        S_FIN_DIV,
        S_FIN_SCALE,
        S_FIN_PICK,
        S_EMIT_DEC
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic rd_en;
        logic update;
        logic emit_mod;
        logic fin_start;
        logic div_init;
        logic div_step;
        logic scale;
        logic pick;
        logic emit_dec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op;
        logic last;
        logic div_done;
        logic mask_last;
        logic out_free;
    } ctrl_sts_t;

    // run length penalty after a run has grown to run
    function automatic logic [1:0] run_add(input logic [RUN_W-1:0] run);
        logic [1:0] a;
        a = 2'd0;
        if (run == 8'd5)
            a = 2'd3;
        else if (run > 8'd5)
            a = 2'd1;
        return a;
    endfunction

    // mask condition from position residues
    function automatic logic mask_flip(
        input logic [2:0] m,
        input logic       r0,
        input logic       c0,
        input logic       r1,
        input logic       cd3,
        input logic [1:0] rm3,
        input logic [1:0] cm3
    );
        logic [2:0] rc_sum;
        logic [1:0] rc3;
        logic [1:0] p3;
        logic       p2;
        logic       f;
        rc_sum = {1'b0, rm3} + {1'b0, cm3};
        rc3    = (rc_sum >= 3'd3) ? 2'(rc_sum - 3'd3) : rc_sum[1:0];
        if (rm3 == 2'd0 || cm3 == 2'd0)
            p3 = 2'd0;
        else if (rm3 == cm3)
            p3 = 2'd1;
        else
            p3 = 2'd2;
        p2 = r0 & c0;
        case (m)
            3'd0:    f = ~(r0 ^ c0);
            3'd1:    f = ~r0;
            3'd2:    f = (cm3 == 2'd0);
            3'd3:    f = (rc3 == 2'd0);
            3'd4:    f = ~(r1 ^ cd3);
            3'd5:    f = (~p2) & (p3 == 2'd0);
            3'd6:    f = ~(p2 ^ p3[0]);
            default: f = ~((r0 ^ c0) ^ p3[0]);
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/qmps_ram.sv
// ----------------------------------------------------------------------------
// qmps_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/qmps_ctrl.sv
// ----------------------------------------------------------------------------
// qmps_ctrl
// Sequencer: module read/update, mask decision loop and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qmps_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output qmps_pkg::ctrl_cmd_t      cmd,
    input  wire qmps_pkg::ctrl_sts_t sts
);

    import qmps_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_UPDATE;
            S_UPDATE:
            begin
                if (sts.op)
                    state_next = S_EMIT_MOD;
                else if (sts.last)
                    state_next = S_FIN_AREA;
                else
                    state_next = S_IDLE;
            end
            S_EMIT_MOD:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            S_FIN_AREA:
                state_next = S_FIN_INIT;
            S_FIN_INIT:
                state_next = S_FIN_DIV;
            S_FIN_DIV:
            begin
                if (sts.div_done)
                    state_next = S_FIN_SCALE;
            end
            S_FIN_SCALE:
                state_next = S_FIN_PICK;
            S_FIN_PICK:
            begin
                if (sts.mask_last)
                    state_next = S_EMIT_DEC;
                else
                    state_next = S_FIN_INIT;
            end
            S_EMIT_DEC:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            S_READ:      cmd.rd_en     = 1'b1;
            S_UPDATE:    cmd.update    = 1'b1;
            S_EMIT_MOD:  cmd.emit_mod  = sts.out_free;
            S_FIN_AREA:  cmd.fin_start = 1'b1;
            S_FIN_INIT:  cmd.div_init  = 1'b1;
            S_FIN_DIV:   cmd.div_step  = 1'b1;
            S_FIN_SCALE: cmd.scale     = 1'b1;
            S_FIN_PICK:  cmd.pick      = 1'b1;
            S_EMIT_DEC:  cmd.emit_dec  = sts.out_free;
            default:     cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/qmps_dp.sv
// ----------------------------------------------------------------------------
// qmps_dp
// Datapath: position tracking, per-mask penalty update, column store,
// dark ratio divider, mask selection and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qmps_dp #(
    parameter int MAX_SIDE = 177
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    input  wire logic [5:0]          cfg_data,
    input  wire logic                in_op,
    input  wire logic                in_bit,
    input  wire logic                in_fn,
    input  wire qmps_pkg::ctrl_cmd_t cmd,
    output qmps_pkg::ctrl_sts_t      sts,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic                     out_kind,
    output logic                     out_bit,
    output logic [2:0]               out_mask,
    output logic [21:0]              out_score
);

    import qmps_pkg::*;

    localparam int          CW     = $clog2(MAX_SIDE);
    localparam int          VMAX   = (MAX_SIDE - 17) / 4;
    localparam logic [5:0]  VMAX_V = 6'(VMAX);

    // configuration
    logic [5:0] ver_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ver_reg <= 6'd1;
        else if (cfg_valid)
            ver_reg <= cfg_data;
    end

    logic [5:0] v_eff;
    logic [7:0] side;
    logic [7:0] side_m1;
    always_comb
    begin
        if (ver_reg == 6'd0)
            v_eff = 6'd1;
        else if (ver_reg > VMAX_V)
            v_eff = VMAX_V;
        else
            v_eff = ver_reg;
        side    = {v_eff, 2'b00} + 8'd17;
        side_m1 = side - 8'd1;
    end

    // latched item
    logic op_reg, bit_reg, fn_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= in_op;
            bit_reg <= in_bit;
            fn_reg  <= in_fn;
        end
    end

    // position and residues; col_pos never exceeds MAX_SIDE-1
    logic [7:0] row_pos_reg, col_pos_reg;
    logic [1:0] rm3_reg, cm3_reg;
    logic       cd3_reg;
    logic       row_end, last;
    assign row_end = col_pos_reg >= side_m1;
    assign last    = row_end && (row_pos_reg >= side_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            rm3_reg     <= '0;
            cm3_reg     <= '0;
            cd3_reg     <= 1'b0;
        end
        else if (cmd.update)
        begin
            if (row_end)
            begin
                col_pos_reg <= '0;
                cm3_reg     <= '0;
                cd3_reg     <= 1'b0;
                if (last)
                begin
                    row_pos_reg <= '0;
                    rm3_reg     <= '0;
                end
                else
                begin
                    row_pos_reg <= row_pos_reg + 8'd1;
                    rm3_reg     <= (rm3_reg == 2'd2) ? 2'd0 : rm3_reg + 2'd1;
                end
            end
            else
            begin
                col_pos_reg <= col_pos_reg + 8'd1;
                cm3_reg     <= (cm3_reg == 2'd2) ? 2'd0 : cm3_reg + 2'd1;
                if (cm3_reg == 2'd2)
                    cd3_reg <= ~cd3_reg;
            end
        end
    end

    logic r_zero, c_zero, r_win, c_win;
    assign r_zero = (row_pos_reg == 8'd0);
    assign c_zero = (col_pos_reg == 8'd0);
    assign r_win  = (row_pos_reg >= 8'(PATTERN_LEN - 1));
    assign c_win  = (col_pos_reg >= 8'(PATTERN_LEN - 1));

    // column store, one row of all masks per column
    logic [CW-1:0]    addr_a, addr_b;
    logic [MEM_W-1:0] rd_a, rd_b, wr_d;
    logic             upd_score;
    assign addr_a    = col_pos_reg[CW-1:0];
    assign addr_b    = c_zero ? '0 : addr_a - CW'(1);
    assign upd_score = cmd.update && !op_reg;

    qmps_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_SIDE)
    ) u_col_ram (
        .clk     (clk),
        .we      (upd_score),
        .waddr   (addr_a),
        .wdata   (wr_d),
        .re      (cmd.rd_en),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    logic [DARK_W-1:0]  dark_a [NUM_MASKS];
    logic [SCORE_W-1:0] pen_a  [NUM_MASKS];

    // per-mask lanes
    for (genvar m = 0; m < NUM_MASKS; m++)
    begin : g_lane
        logic [RUN_W-1:0]   row_run_reg;
        logic [RWIN_W-1:0]  row_win_reg;
        logic [DARK_W-1:0]  dark_reg;
        logic [SCORE_W-1:0] pen_reg;

        logic               b;
        logic [RUN_W-1:0]   crun, rr_inc, cr_inc, rr_new, cr_new;
        logic [CWIN_W-1:0]  cw, ulw, cw_new;
        logic [RWIN_W-1:0]  rw_new, cw_ext;
        logic [1:0]         rr_add, cr_add;
        logic               blk, rfind, cfind;
        logic [6:0]         inc;
        logic [SCORE_W:0]   pen_sum;

        always_comb
        begin
            b = bit_reg ^ (~fn_reg & mask_flip(3'(m), row_pos_reg[0], col_pos_reg[0],
                                               row_pos_reg[1], cd3_reg, rm3_reg, cm3_reg));
            crun = rd_a[m*CENT_W + CWIN_W +: RUN_W];
            cw   = rd_a[m*CENT_W +: CWIN_W];
            ulw  = rd_b[m*CENT_W +: CWIN_W];

            // rule 1, rows
            rr_inc = (row_run_reg < RUN_MAX) ? row_run_reg + 8'd1 : row_run_reg;
            if (!c_zero && row_win_reg[0] == b)
            begin
                rr_new = rr_inc;
                rr_add = run_add(rr_inc);
            end
            else
            begin
                rr_new = 8'd1;
                rr_add = 2'd0;
            end

            // rule 1, columns
            cr_inc = (crun < RUN_MAX) ? crun + 8'd1 : crun;
            if (!r_zero && cw[0] == b)
            begin
                cr_new = cr_inc;
                cr_add = run_add(cr_inc);
            end
            else
            begin
                cr_new = 8'd1;
                cr_add = 2'd0;
            end

            // rule 2
            blk = !r_zero && !c_zero && ulw[1] == b && cw[0] == b && row_win_reg[0] == b;

            // rule 3
            rw_new = c_zero ? {{(RWIN_W-1){1'b0}}, b} : {row_win_reg[RWIN_W-2:0], b};
            rfind  = c_win && (rw_new == FINDER_A || rw_new == FINDER_B);
            cw_ext = {cw, b};
            cfind  = r_win && (cw_ext == FINDER_A || cw_ext == FINDER_B);
            cw_new = r_zero ? {{(CWIN_W-1){1'b0}}, b} : {cw[CWIN_W-2:0], b};

            inc = {5'd0, rr_add} + {5'd0, cr_add}
                + (blk   ? PEN_BLOCK : 7'd0)
                + (rfind ? PEN_FIND  : 7'd0)
                + (cfind ? PEN_FIND  : 7'd0);
            pen_sum = {1'b0, pen_reg} + (SCORE_W+1)'(inc);
        end

        assign wr_d[m*CENT_W +: CENT_W] = {cr_new, cw_new};
        assign dark_a[m] = dark_reg;
        assign pen_a[m]  = pen_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                row_run_reg <= '0;
                row_win_reg <= '0;
                dark_reg    <= '0;
                pen_reg     <= '0;
            end
            else if (cmd.emit_dec)
            begin
                row_run_reg <= '0;
                row_win_reg <= '0;
                dark_reg    <= '0;
                pen_reg     <= '0;
            end
            else if (upd_score)
            begin
                row_run_reg <= rr_new;
                row_win_reg <= rw_new;
                if (b && dark_reg < DARK_MAX)
                    dark_reg <= dark_reg + 15'd1;
                pen_reg <= (pen_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : pen_sum[SCORE_W-1:0];
            end
        end
    end

    // apply pass result bit
    logic [2:0] chosen_reg;
    logic       res_bit_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.update && op_reg)
            res_bit_reg <= bit_reg ^ (~fn_reg & mask_flip(chosen_reg, row_pos_reg[0],
                col_pos_reg[0], row_pos_reg[1], cd3_reg, rm3_reg, cm3_reg));
    end

    // dark percentage: restoring divider, one quotient bit per cycle
    logic [2:0]         fin_m_reg;
    logic [AREA_W-1:0]  area_reg;
    logic [AREA_W-1:0]  rem_reg;
    logic [DIVD_W-1:0]  dq_reg;
    logic [4:0]         cnt_reg;
    logic [AREA_W:0]    trial;
    logic               ge;
    logic [15:0]        area_full;

    assign area_full = side * side;
    assign trial     = {rem_reg, dq_reg[DIVD_W-1]};
    assign ge        = trial >= {1'b0, area_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.fin_start)
            area_reg <= area_full[AREA_W-1:0];
        if (cmd.div_init)
        begin
            dq_reg  <= DIVD_W'(dark_a[fin_m_reg]) * DIVD_W'(PCT_SCALE);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? AREA_W'(trial - {1'b0, area_reg}) : trial[AREA_W-1:0];
            dq_reg  <= {dq_reg[DIVD_W-2:0], ge};
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    // deviation from half, divided by five through a reciprocal
    logic [PCT_W-1:0]  pct, dev;
    logic [PROD_W-1:0] prod_reg;
    logic [11:0]       dev5;
    logic [15:0]       r4;
    logic [SCORE_W:0]  s_sum;
    logic [SCORE_W-1:0] s_fin;

    assign pct = dq_reg[PCT_W-1:0];
    assign dev = (pct >= PCT_HALF) ? pct - PCT_HALF : PCT_HALF - pct;

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
            prod_reg <= PROD_W'(dev) * PROD_W'(RECIP5);
    end

    assign dev5  = prod_reg[29:18];
    assign r4    = {1'b0, dev5, 3'b000} + {3'b000, dev5, 1'b0};
    assign s_sum = {1'b0, pen_a[fin_m_reg]} + (SCORE_W+1)'(r4);
    assign s_fin = (s_sum > {1'b0, SCORE_MAX}) ? SCORE_MAX : s_sum[SCORE_W-1:0];

    // best mask, lowest index wins ties
    logic [2:0]         best_m_reg;
    logic [SCORE_W-1:0] best_s_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_m_reg <= '0;
        else if (cmd.fin_start)
            fin_m_reg <= '0;
        else if (cmd.pick)
            fin_m_reg <= fin_m_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick && (fin_m_reg == 3'd0 || s_fin < best_s_reg))
        begin
            best_m_reg <= fin_m_reg;
            best_s_reg <= s_fin;
        end
    end

    // output register
    logic               out_valid_reg, out_kind_reg, out_bit_reg;
    logic [2:0]         out_mask_reg;
    logic [SCORE_W-1:0] out_score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            chosen_reg    <= '0;
        end
        else if (cmd.emit_mod || cmd.emit_dec)
        begin
            out_valid_reg <= 1'b1;
            if (cmd.emit_dec)
                chosen_reg <= best_m_reg;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_mod)
        begin
            out_kind_reg  <= 1'b0;
            out_bit_reg   <= res_bit_reg;
            out_mask_reg  <= chosen_reg;
            out_score_reg <= '0;
        end
        else if (cmd.emit_dec)
        begin
            out_kind_reg  <= 1'b1;
            out_bit_reg   <= 1'b0;
            out_mask_reg  <= best_m_reg;
            out_score_reg <= best_s_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_bit   = out_bit_reg;
    assign out_mask  = out_mask_reg;
    assign out_score = out_score_reg;

    // status
    always_comb
    begin
        sts.op        = op_reg;
        sts.last      = last;
        sts.div_done  = (cnt_reg == 5'(DIV_STEPS - 1));
        sts.mask_last = (fin_m_reg == 3'(NUM_MASKS - 1));
        sts.out_free  = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

### hw/rtl/qr_mask_penalty_select_top.sv
// Apply-pass requests go through the read, update and emit states before the
// result is registered; emit waits while an earlier result is untaken. A new
// request is taken only once the last is through. The last score-pass module
// gives the decision after the 22-step dark ratio divider ran for each mask.
// Reset: asynchronous; control, row state and scores clear at once, the
// column store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// qr_mask_penalty_select_top
// QR data mask penalty evaluation, mask selection and mask application.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qr_mask_penalty_select_top #(
    parameter int MAX_SIDE = 177
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data,      // symbol_version
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [0] module_bit, [7:1] zero
    input  wire logic [1:0]  s_axis_tuser,  // [0] op, [1] is_function
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [0] masked_bit, [3:1] best_mask,
                                            // [25:4] best_score, [31:26] zero
    output logic [0:0]       m_axis_tuser   // [0] result_kind
);

    import qmps_pkg::*;

    ctrl_cmd_t   cmd;
    ctrl_sts_t   sts;
    logic        o_kind, o_bit;
    logic [2:0]  o_mask;
    logic [21:0] o_score;

    assign cfg_ready = 1'b1;

    qmps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    qmps_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tuser[0]),
        .in_bit    (s_axis_tdata[0]),
        .in_fn     (s_axis_tuser[1]),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_kind  (o_kind),
        .out_bit   (o_bit),
        .out_mask  (o_mask),
        .out_score (o_score)
    );

    // output packing
    assign m_axis_tdata = {6'd0, o_score, o_mask, o_bit};
    assign m_axis_tuser = o_kind;

endmodule

`default_nettype wire

### hw/rtl/qmps_checker.sv
// ----------------------------------------------------------------------------
// qmps_checker
// Port-level checks of the request streams, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module qmps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // decision requests carry no module bit
    `ASSERT_IMP(a_dec_bit_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
                m_axis_tdata[0] == 1'b0)

    // module requests carry no score
    `ASSERT_IMP(a_mod_score_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0],
                m_axis_tdata[25:4] == 22'd0)

    // padding stays zero
    `ASSERT_IMP(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[31:26] == 6'd0)

    // stalled result holds
    `ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one request at a time: input closes after a take
    `ASSERT_NXT(a_in_close, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind qr_mask_penalty_select_top qmps_checker u_qmps_checker (.*);

`default_nettype wire

### bench/tb_qr_mask_penalty_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qr_mask_penalty_select_top
// Streams QR modules through score and apply passes at several symbol
// versions and idle patterns. A built-in penalty predictor works out every
// masked module and mask decision, and a checker compares each returned
// request in order.
// ----------------------------------------------------------------------------
module tb_qr_mask_penalty_select_top;
    import qmps_pkg::*;

    localparam int SIDE_CAP  = 177;
    localparam int SEND_OFF  = 0;
    localparam int SEND_BUSY = 1;
    localparam int RECV_BUSY = 2;
    localparam int BOTH_BUSY = 3;
    localparam bit OP_SCORE  = 1'b0;
    localparam bit OP_APPLY  = 1'b1;
    localparam bit KIND_MOD  = 1'b0;
    localparam bit KIND_DEC  = 1'b1;
    // content styles for generated modules
    localparam int ST_RANDOM = 0;
    localparam int ST_FUNC   = 1;
    localparam int ST_CHECK  = 2;
    localparam int ST_FINDER = 3;

    typedef struct {
        bit        kind;
        bit        mbit;
        bit [2:0]  mask;
        bit [21:0] score;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    outcome_t expected_q[$];
    int       mismatches = 0;
    int       idle_mode = SEND_OFF;
    int       hold_left = 0;

    // predictor state
    int unsigned version_q = 1;
    int unsigned row_q, col_q, picked;
    int unsigned run_r[NUM_MASKS], win_r[NUM_MASKS];
    int unsigned dark[NUM_MASKS], penalty[NUM_MASKS];
    int unsigned run_c[SIDE_CAP*NUM_MASKS], win_c[SIDE_CAP*NUM_MASKS];

    qr_mask_penalty_select_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic int unsigned side_of(int unsigned v);
        if (v < 1) v = 1;
        if (v > (SIDE_CAP - 17) / 4) v = (SIDE_CAP - 17) / 4;
        return 4 * v + 17;
    endfunction

    function automatic bit flips(int unsigned m, int unsigned r, int unsigned c);
        int unsigned p;
        p = r * c;
        case (m)
            0: return ((r + c) % 2) == 0;
            1: return (r % 2) == 0;
            2: return (c % 3) == 0;
            3: return ((r + c) % 3) == 0;
            4: return ((r / 2 + c / 3) % 2) == 0;
            5: return (p % 2 + p % 3) == 0;
            6: return ((p % 2 + p % 3) % 2) == 0;
            default: return (((r + c) % 2 + p % 3) % 2) == 0;
        endcase
    endfunction

    function automatic void add_penalty(int unsigned m, int unsigned v);
        penalty[m] = (penalty[m] + v > SCORE_MAX) ? SCORE_MAX : penalty[m] + v;
    endfunction

    function automatic int unsigned grow_run(int unsigned m, int unsigned run);
        if (run < 255) run++;
        if (run == 5) add_penalty(m, 3);
        else if (run > 5) add_penalty(m, 1);
        return run;
    endfunction

    function automatic void clear_scores();
        for (int m = 0; m < NUM_MASKS; m++)
        begin
            run_r[m] = 0; win_r[m] = 0; dark[m] = 0; penalty[m] = 0;
        end
    endfunction

    // module value for a content style at the current position
    function automatic bit style_bit(int style);
        bit mod;
        case (style)
            ST_FUNC:   mod = 1'b1;
            ST_CHECK:  mod = 1'((row_q + col_q) % 2);
            ST_FINDER: mod = FINDER_A[10 - (col_q % 11)] ^ row_q[0];
            default:   mod = 1'($urandom_range(1));
        endcase
        return mod;
    endfunction

    // advance the penalty model by one module; returns 1 at the pass end
    function automatic bit penalty_step(bit op, bit mod, bit fn);
        int unsigned side, r, c, ci, cw, rw, w, area, pct, dev, s, best, best_s;
        bit          row_end, last, b;
        outcome_t    o;
        side = side_of(version_q);
        r = row_q;
        c = (col_q >= SIDE_CAP) ? SIDE_CAP - 1 : col_q;
        row_end = c >= side - 1;
        last = row_end && r >= side - 1;
        if (row_end)
        begin
            col_q = 0;
            row_q = last ? 0 : (r + 1) & 8'hFF;
        end
        else
            col_q = c + 1;
        if (op == OP_APPLY)
        begin
            o.kind = KIND_MOD;
            o.mbit = mod ^ (!fn && flips(picked, r, c));
            o.mask = picked;
            o.score = 0;
            expected_q.push_back(o);
            return last;
        end
        for (int unsigned m = 0; m < NUM_MASKS; m++)
        begin
            b = mod ^ (!fn && flips(m, r, c));
            ci = c * NUM_MASKS + m;
            cw = win_c[ci];
            // runs along the row and the column
            if (c == 0) run_r[m] = 1;
            else if ((win_r[m] & 1) == b) run_r[m] = grow_run(m, run_r[m]);
            else run_r[m] = 1;
            if (r == 0) run_c[ci] = 1;
            else if ((cw & 1) == b) run_c[ci] = grow_run(m, run_c[ci]);
            else run_c[ci] = 1;
            // uniform 2x2 block
            if (r > 0 && c > 0)
                if (((win_c[ci-NUM_MASKS] >> 1) & 1) == b && (cw & 1) == b &&
                    (win_r[m] & 1) == b)
                    add_penalty(m, 3);
            // finder-like windows
            rw = (c == 0) ? b : (((win_r[m] << 1) | b) & 11'h7FF);
            win_r[m] = rw;
            if (c >= PATTERN_LEN - 1 && (rw == FINDER_A || rw == FINDER_B))
                add_penalty(m, 40);
            if (r >= PATTERN_LEN - 1)
            begin
                w = ((cw << 1) | b) & 11'h7FF;
                if (w == FINDER_A || w == FINDER_B) add_penalty(m, 40);
            end
            win_c[ci] = (r == 0) ? b : (((cw << 1) | b) & 10'h3FF);
            if (b && dark[m] < DARK_MAX) dark[m]++;
        end
        if (!last) return 0;
        // dark balance term and pick the cheapest mask
        area = side * side;
        best = 0; best_s = 0;
        for (int unsigned m = 0; m < NUM_MASKS; m++)
        begin
            pct = dark[m] * 100 / area;
            dev = (pct >= 50) ? pct - 50 : 50 - pct;
            s = penalty[m] + (dev / 5) * 10;
            if (s > SCORE_MAX) s = SCORE_MAX;
            if (m == 0 || s < best_s)
            begin
                best_s = s; best = m;
            end
        end
        picked = best;
        clear_scores();
        o.kind = KIND_DEC; o.mbit = 0; o.mask = best; o.score = best_s;
        expected_q.push_back(o);
        return 1;
    endfunction

    // offer one module request and model it once taken
    task automatic send_module(bit op, bit mod, bit fn, output bit last);
        int gap;
        gap = (idle_mode == SEND_BUSY) ? 77 : (idle_mode == BOTH_BUSY) ? 22 : 0;
        while ($urandom_range(99) < gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, mod};
        s_axis_tuser  <= {fn, op};
        do @(posedge clk); while (!s_axis_tready);
        last = penalty_step(op, mod, fn);
        @(negedge clk);
    endtask

    task automatic go_quiet();
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (250) @(negedge clk);
    endtask

    task automatic write_version(bit [5:0] v);
        go_quiet();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        version_q = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // rest of a pass from the current position; stray opposite ops stay off
    // the first row, whose column entries may not be written yet, and off
    // the last row, so that the pass ends on its own op
    task automatic run_pass(bit op, int style, int stray);
        bit last, mod, fn, o;
        last = 0;
        while (!last)
        begin
            mod = style_bit(style);
            fn = (style == ST_FUNC) ? 1'b1 : ($urandom_range(7) == 0);
            o = (row_q != 0 && row_q + 1 < side_of(version_q) &&
                 $urandom_range(99) < stray) ? ~op : op;
            send_module(o, mod, fn, last);
        end
    endtask

    // a fixed number of modules of one op
    task automatic run_items(bit op, int style, int n);
        bit last, mod, fn;
        for (int i = 0; i < n; i++)
        begin
            mod = style_bit(style);
            fn = (style == ST_FUNC) ? 1'b1 : ($urandom_range(7) == 0);
            send_module(op, mod, fn, last);
        end
    endtask

    task automatic test_version_extremes();
        idle_mode = SEND_OFF;
        // out of range version clamps to the largest; then lowered mid-pass
        write_version(6'd63);
        run_items(OP_SCORE, ST_RANDOM, 25);
        write_version(6'd1);
    endtask

    task automatic test_directed();
        bit last;
        idle_mode = SEND_OFF;
        // every field combination, both ops mixed inside one score pass
        for (int i = 0; i < 8; i++)
            send_module(i[0], i[1], i[2], last);
        send_module(OP_APPLY, 1'b1, 1'b0, last);
        send_module(OP_SCORE, 1'b0, 1'b0, last);
        run_pass(OP_SCORE, ST_FINDER, 5);
    endtask

    task automatic test_idle_phases();
        int styles[4] = '{ST_RANDOM, ST_CHECK, ST_FUNC, ST_RANDOM};
        write_version(6'd0);
        for (int k = 0; k < 4; k++)
        begin
            idle_mode = k;
            run_items(OP_APPLY, styles[k], 40);
        end
        idle_mode = SEND_OFF;
    endtask

    task automatic test_backpressure();
        idle_mode = SEND_OFF;
        hold_left = 400;
        run_items(OP_APPLY, ST_RANDOM, 40);
    endtask

    // receiver ready: long hold-off first, then random stalls per phase
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (idle_mode == RECV_BUSY)
            m_axis_tready <= $urandom_range(99) >= 77;
        else if (idle_mode == BOTH_BUSY)
            m_axis_tready <= $urandom_range(99) >= 22;
        else
            m_axis_tready <= 1'b1;
    end

    // compare each returned request with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result tdata=%h tuser=%b", m_axis_tdata,
                             m_axis_tuser);
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_axis_tuser[0] !== e.kind || m_axis_tdata[0] !== e.mbit ||
                    m_axis_tdata[3:1] !== e.mask || m_axis_tdata[25:4] !== e.score)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind=%0d bit=%0d mask=%0d score=%0d,",
                                  " got kind=%0d bit=%0d mask=%0d score=%0d"},
                                 e.kind, e.mbit, e.mask, e.score, m_axis_tuser[0],
                                 m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[25:4]);
                end
            end
        end
    end

    initial
    begin
        row_q = 0; col_q = 0; picked = 0;
        clear_scores();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_version_extremes();
        test_directed();
        test_idle_phases();
        test_backpressure();
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/qmps_pkg.sv
hw/rtl/qmps_ram.sv
hw/rtl/qmps_ctrl.sv
hw/rtl/qmps_dp.sv
hw/rtl/qr_mask_penalty_select_top.sv
hw/rtl/qmps_checker.sv
bench/tb_qr_mask_penalty_select_top.sv
